// ===== hw/rtl/spmq_pkg.sv =====
// Shared types, sizing constants and helper functions for the strict-priority
// multi-level queue. No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package spmq_pkg;

   localparam int NUM_LEVELS  = 5;
   localparam int LEVEL_DEPTH = 16;
   localparam int DATA_WIDTH  = 32;

   localparam int LVL_W     = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int PTR_W     = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int CNT_W     = $clog2(LEVEL_DEPTH + 1);
   localparam int MEM_DEPTH = NUM_LEVELS * LEVEL_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   // Field widths fixed by the stream format
   localparam int VALUE_W = 32;
   localparam int LEVEL_W = 3;
   localparam int TDATA_W = 40;

   typedef enum logic [2:0] {
      ST_ENQUEUED = 3'd0,
      ST_DEQUEUED = 3'd1,
      ST_INVALID  = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic {
      MODE_ENQUEUE = 1'b0,
      MODE_DEQUEUE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LOAD,
      S_RESP
   } state_type;

   typedef struct packed {
      logic load_req;    // capture the incoming request
      logic exec;        // decide, update pointers, touch the store
      logic load_value;  // move store read data into the response
   } dp_cmd_type;

   typedef struct packed {
      logic read_issued; // current request reads the store
   } dp_status_type;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(LEVEL_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   function automatic logic [ADDR_W-1:0] mem_addr(input logic [LVL_W-1:0] q,
                                                  input logic [PTR_W-1:0] p);
      return ADDR_W'(q) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(p);
   endfunction

endpackage

// ===== hw/rtl/spmq_ctrl.sv =====
// Sequencing state machine for the priority queue: handshakes and datapath
// commands. Depends on spmq_pkg.
`timescale 1ns / 1ps

module spmq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output spmq_pkg::dp_cmd_type    cmd,
   input  spmq_pkg::dp_status_type stat
);
   import spmq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = stat.read_issued ? S_LOAD : S_RESP;
         end
         S_LOAD: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready     = 1'b0;
      rsp_tvalid     = 1'b0;
      cmd            = '0;
      case (state_ff)
         S_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
         end
         S_LOAD: begin
            cmd.load_value = 1'b1;
         end
         S_RESP: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/spmq_dpath.sv =====
// Datapath of the priority queue: request and response registers, per-level
// ring pointers and counts, priority encoder and the shared item store.
// Depends on spmq_pkg.
`timescale 1ns / 1ps

module spmq_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  spmq_pkg::dp_cmd_type           cmd,
   output spmq_pkg::dp_status_type        stat,
   input  logic                          in_mode,
   input  logic signed [spmq_pkg::VALUE_W-1:0] in_value,
   input  logic [spmq_pkg::LEVEL_W-1:0]  in_level,
   output spmq_pkg::status_type           out_status,
   output logic signed [spmq_pkg::VALUE_W-1:0] out_value,
   output logic [spmq_pkg::LEVEL_W-1:0]  out_level
);
   import spmq_pkg::*;

   logic                  req_mode_ff;
   logic [VALUE_W-1:0]    req_value_ff;
   logic [LEVEL_W-1:0]    req_level_ff;

   logic [PTR_W-1:0]      head_ff [NUM_LEVELS];
   logic [PTR_W-1:0]      tail_ff [NUM_LEVELS];
   logic [CNT_W-1:0]      cnt_ff  [NUM_LEVELS];

   logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
   logic [DATA_WIDTH-1:0] mem_rd_ff;

   status_type            rsp_status_ff;
   logic [VALUE_W-1:0]    rsp_value_ff;
   logic [LEVEL_W-1:0]    rsp_level_ff;

   logic [LEVEL_W-1:0]    lvl_m1;
   logic [LVL_W-1:0]      q_enq;
   logic                  level_ok;
   logic                  is_full;
   logic                  hit;
   logic [LVL_W-1:0]      q_deq;
   logic [LEVEL_W-1:0]    deq_level;
   logic                  do_write;
   logic                  do_read;
   status_type            status_in;
   logic [63:0]           wr_ext;
   logic [63:0]           rd_ext;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_mode_ff  <= in_mode;
         req_value_ff <= in_value;
         req_level_ff <= in_level;
      end
   end

   assign lvl_m1   = req_level_ff - LEVEL_W'(1);
   assign q_enq    = lvl_m1[LVL_W-1:0];
   assign level_ok = (req_level_ff != '0) && (req_level_ff <= LEVEL_W'(NUM_LEVELS));
   assign is_full  = level_ok && (cnt_ff[q_enq] == CNT_W'(LEVEL_DEPTH));

   // Most urgent non-empty level wins
   always_comb begin
      hit   = 1'b0;
      q_deq = '0;
      for (int q = NUM_LEVELS - 1; q >= 0; q--) begin
         if (cnt_ff[q] != '0) begin
            hit   = 1'b1;
            q_deq = LVL_W'(q);
         end
      end
   end

   assign deq_level = LEVEL_W'(q_deq) + LEVEL_W'(1);

   always_comb begin
      if (req_mode_ff == MODE_DEQUEUE) begin
         status_in = hit ? ST_DEQUEUED : ST_EMPTY;
      end else if (!level_ok) begin
         status_in = ST_INVALID;
      end else if (is_full) begin
         status_in = ST_FULL;
      end else begin
         status_in = ST_ENQUEUED;
      end
   end

   assign do_write         = cmd.exec && (status_in == ST_ENQUEUED);
   assign do_read          = cmd.exec && (status_in == ST_DEQUEUED);
   assign stat.read_issued = (status_in == ST_DEQUEUED);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < NUM_LEVELS; q++) begin
            head_ff[q] <= '0;
            tail_ff[q] <= '0;
            cnt_ff[q]  <= '0;
         end
      end else begin
         if (do_write) begin
            tail_ff[q_enq] <= next_ptr(tail_ff[q_enq]);
            cnt_ff[q_enq]  <= cnt_ff[q_enq] + CNT_W'(1);
         end
         if (do_read) begin
            head_ff[q_deq] <= next_ptr(head_ff[q_deq]);
            cnt_ff[q_deq]  <= cnt_ff[q_deq] - CNT_W'(1);
         end
      end
   end

   assign wr_ext = {32'd0, req_value_ff};

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[mem_addr(q_enq, tail_ff[q_enq])] <= wr_ext[DATA_WIDTH-1:0];
      end
      if (do_read) begin
         mem_rd_ff <= mem[mem_addr(q_deq, head_ff[q_deq])];
      end
   end

   assign rd_ext = 64'(mem_rd_ff);

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_status_ff <= status_in;
         rsp_level_ff  <= (status_in == ST_DEQUEUED) ? deq_level : '0;
         rsp_value_ff  <= '0;
      end else if (cmd.load_value) begin
         rsp_value_ff  <= rd_ext[VALUE_W-1:0];
      end
   end

   assign out_status = rsp_status_ff;
   assign out_value  = rsp_value_ff;
   assign out_level  = rsp_level_ff;

endmodule

// ===== hw/rtl/strict_priority_multi_queue_unit.sv =====
// Enqueue, invalid and empty results raise rsp_tvalid after the execute state; a dequeue
// that finds an item also passes through the load state for the store read data.
// One request is handled at a time: no new request is taken until its response is delivered,
// set by the control sequence around the single-port item store and its read register.
// Reset clears pointers and fill counts at once; the store itself is not cleared.
// Top level; depends on spmq_pkg, spmq_ctrl and spmq_dpath.
`timescale 1ns / 1ps

module strict_priority_multi_queue_unit (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [spmq_pkg::TDATA_W-1:0]   req_tdata,  // [31:0] value, [34:32] level, rest zero
   input  logic [0:0]                     req_tuser,  // [0] mode (0 enqueue, 1 dequeue)
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [spmq_pkg::TDATA_W-1:0]   rsp_tdata,  // [31:0] out_value, [34:32] out_level
   output logic [2:0]                     rsp_tuser   // [2:0] status
);
   import spmq_pkg::*;

   dp_cmd_type            cmd;
   dp_status_type         stat;
   status_type            out_status;
   logic signed [VALUE_W-1:0] out_value;
   logic [LEVEL_W-1:0]    out_level;

   // The controller walks one request at a time: take it, execute it against
   // the pointers and the store, pull the read data if a dequeue hit, then
   // hold the response until the consumer takes it.
   spmq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // Datapath holds the request, the per-level rings and the response register
   spmq_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_mode    (req_tuser[0]),
      .in_value   (req_tdata[VALUE_W-1:0]),
      .in_level   (req_tdata[VALUE_W +: LEVEL_W]),
      .out_status (out_status),
      .out_value  (out_value),
      .out_level  (out_level)
   );

   // Pack the response: zero pad above the level field
   assign rsp_tdata = {{(TDATA_W - VALUE_W - LEVEL_W){1'b0}}, out_level, out_value};
   assign rsp_tuser = out_status;

endmodule

// ===== hw/rtl/spmq_checker.sv =====
// Port-level checks for the priority queue top level, attached by bind.
// Depends on spmq_pkg and strict_priority_multi_queue_unit.
`timescale 1ns / 1ps

module spmq_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic [spmq_pkg::TDATA_W-1:0] req_tdata,
   input logic [0:0]                   req_tuser,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [spmq_pkg::TDATA_W-1:0] rsp_tdata,
   input logic [2:0]                   rsp_tuser
);
   import spmq_pkg::*;

   logic unused_ok;
   assign unused_ok = ^{req_tdata, req_tuser};

   // Stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // One request in flight: no new request until its response is delivered
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !rsp_tvalid)
      else $error("request taken while another is in flight");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request ready while a response waits");

   // Only a dequeue carries data
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_DEQUEUED) |-> rsp_tdata == '0)
      else $error("nonzero payload on non-dequeue response");

   a_deq_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_DEQUEUED) |->
         (rsp_tdata[VALUE_W +: LEVEL_W] != '0) &&
         (rsp_tdata[VALUE_W +: LEVEL_W] <= LEVEL_W'(NUM_LEVELS)))
      else $error("dequeued level out of range");

endmodule

bind strict_priority_multi_queue_unit spmq_checker u_spmq_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for strict_priority_multi_queue_unit: random and directed
// enqueue/dequeue requests against an in-bench priority queue model.
// Depends on spmq_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;

   import spmq_pkg::*;

   localparam int RANDOM_ITEMS   = 550;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;

   // One expected reply of the queue
   typedef struct {
      status_type      status;
      logic [31:0]     value;
      logic [2:0]      level;
   } queue_reply_type;

   typedef enum {
      PH_FILL,
      PH_DRAIN,
      PH_MIXED,
      PH_HOT
   } phase_kind_type;

   // Tracks the per-level rings and the replies still owed by the block
   class level_queue_book;
      logic [DATA_WIDTH-1:0] slot_data [NUM_LEVELS][LEVEL_DEPTH];
      int unsigned           rd_pos [NUM_LEVELS];
      int unsigned           wr_pos [NUM_LEVELS];
      int unsigned           held   [NUM_LEVELS];
      queue_reply_type       awaited_replies [$];
      int                    mismatch_count;

      function new();
         for (int q = 0; q < NUM_LEVELS; q++) begin
            rd_pos[q] = 0;
            wr_pos[q] = 0;
            held[q]   = 0;
         end
         mismatch_count = 0;
      endfunction

      task report(input string what);
         $display("mismatch at %0t: %s", $realtime, what);
         mismatch_count++;
      endtask

      function int pending();
         return awaited_replies.size();
      endfunction

      // Work out the reply to an accepted request and queue it
      function void note_request(input mode_type mode, input logic [31:0] value,
                                 input logic [2:0] level);
         queue_reply_type r;
         int              q;
         bit              found;
         r.status = ST_EMPTY;
         r.value  = '0;
         r.level  = '0;
         if (mode == MODE_ENQUEUE) begin
            if (level == 0 || level > NUM_LEVELS) begin
               r.status = ST_INVALID;
            end else begin
               q = int'(level) - 1;
               if (held[q] >= LEVEL_DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  slot_data[q][wr_pos[q]] = DATA_WIDTH'(value);
                  wr_pos[q] = (wr_pos[q] + 1 == LEVEL_DEPTH) ? 0 : wr_pos[q] + 1;
                  held[q]++;
                  r.status = ST_ENQUEUED;
               end
            end
         end else begin
            found = 0;
            for (q = 0; q < NUM_LEVELS; q++) begin
               if (!found && held[q] != 0) begin
                  r.value  = 32'(slot_data[q][rd_pos[q]]);
                  r.level  = 3'(q + 1);
                  r.status = ST_DEQUEUED;
                  rd_pos[q] = (rd_pos[q] + 1 == LEVEL_DEPTH) ? 0 : rd_pos[q] + 1;
                  held[q]--;
                  found = 1;
               end
            end
         end
         awaited_replies.push_back(r);
      endfunction

      // Compare one accepted reply with the oldest one owed
      task check_result(input logic [2:0] status, input logic [31:0] value,
                        input logic [2:0] level);
         queue_reply_type r;
         if (awaited_replies.size() == 0) begin
            report($sformatf("unexpected reply status %0d value %h level %0d",
                             status, value, level));
         end else begin
            r = awaited_replies.pop_front();
            if (3'(r.status) !== status)
               report($sformatf("status %0d, want %0d", status, r.status));
            if (r.value !== value)
               report($sformatf("value %h, want %h", value, r.value));
            if (r.level !== level)
               report($sformatf("level %0d, want %0d", level, r.level));
         end
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [TDATA_W-1:0]   req_tdata;
   logic [0:0]           req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [TDATA_W-1:0]   rsp_tdata;
   logic [2:0]           rsp_tuser;

   level_queue_book sb;
   int              burst_left;
   int              idle_cycles;

   strict_priority_multi_queue_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Pick a value, leaning on the sign and all-ones/all-zero corners now and then
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Mostly legal levels; favor a hot level when one is given
   function automatic logic [2:0] pick_level(input int hot);
      if ($urandom_range(0, 99) < 10) begin
         return ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(NUM_LEVELS + 1, 7));
      end
      if (hot > 0 && $urandom_range(0, 99) < 60) begin
         return 3'(hot);
      end
      return 3'($urandom_range(1, NUM_LEVELS));
   endfunction

   // Drive one request at the falling edge and hold it until accepted.
   // Between bursts drop valid for a random gap; a zero gap keeps the stream tight.
   task automatic send_request(input mode_type mode, input logic [31:0] value,
                               input logic [2:0] level);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = TDATA_W'({level, value});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(mode, value, level);
      @(negedge clock);
   endtask

   // Receiver: long open stretches mixed with short ready/stall runs
   initial begin
      int run;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 99) < 25) begin
            rsp_tready = 1'b1;
            repeat ($urandom_range(10, 60)) @(negedge clock);
         end else begin
            run = $urandom_range(1, 8);
            rsp_tready = 1'b1;
            repeat (run) @(negedge clock);
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end
      end
   end

   // Check every accepted reply against the model
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tuser, rsp_tdata[VALUE_W-1:0],
                         rsp_tdata[VALUE_W+LEVEL_W-1:VALUE_W]);
      end
   end

   // Watchdog: end the run if no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      phase_kind_type kind;
      int             sent;
      int             span;
      int             enq_pct;
      int             hot;
      mode_type       mode;

      sb          = new();
      burst_left  = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty queue, bad priorities, extreme values, urgency order
      send_request(MODE_DEQUEUE, 32'hffff_ffff, 3'd7);   // empty; fields ignored
      send_request(MODE_ENQUEUE, 32'h1234_5678, 3'd0);   // invalid priority
      send_request(MODE_ENQUEUE, 32'h1234_5678, 3'(NUM_LEVELS + 1));
      send_request(MODE_ENQUEUE, 32'h1234_5678, 3'd7);
      send_request(MODE_ENQUEUE, 32'h7fff_ffff, 3'(NUM_LEVELS));
      send_request(MODE_ENQUEUE, 32'h8000_0000, 3'd3);
      send_request(MODE_ENQUEUE, 32'h0000_0000, 3'd1);
      send_request(MODE_ENQUEUE, 32'hffff_ffff, 3'd1);
      send_request(MODE_ENQUEUE, 32'h0000_0001, 3'd2);
      send_request(MODE_DEQUEUE, 32'h0000_0000, 3'd0);
      send_request(MODE_DEQUEUE, 32'hdead_beef, 3'd5);
      send_request(MODE_ENQUEUE, 32'ha5a5_a5a5, 3'd1);   // urgent one arrives late
      repeat (5) send_request(MODE_DEQUEUE, $urandom, 3'($urandom_range(0, 7)));
      send_request(MODE_DEQUEUE, 32'h0000_0000, 3'd0);

      // Random phases: fill, drain, mix, and hammer one hot level
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         kind = phase_kind_type'($urandom_range(0, 3));
         span = $urandom_range(20, 70);
         if (span > RANDOM_ITEMS - sent) span = RANDOM_ITEMS - sent;
         hot  = 0;
         case (kind)
            PH_FILL:  enq_pct = 85;
            PH_DRAIN: enq_pct = 20;
            PH_MIXED: enq_pct = 50;
            default: begin
               enq_pct = 90;
               hot     = $urandom_range(1, NUM_LEVELS);
            end
         endcase
         repeat (span) begin
            mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQUEUE : MODE_DEQUEUE;
            if (mode == MODE_ENQUEUE)
               send_request(mode, pick_value(), pick_level(hot));
            else
               send_request(mode, $urandom, 3'($urandom_range(0, 7)));
            sent++;
         end
      end
      req_tvalid = 1'b0;

      // Drain: wait for every owed reply, then let the pipeline settle
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
